// ===== hw/rtl/cfpr_pkg.sv =====
// Shared types and constants for the card frame parser and responder.
// No dependencies; the RTL files refer to it by scoped names, the testbench files import it.
`default_nettype none

package cfpr_pkg;

   // Response bytes and command codes
   localparam logic [7:0] NAK_BYTE      = 8'h15;
   localparam logic [7:0] CMD_CONTROL   = 8'h31;
   localparam logic [7:0] CMD_QUERY     = 8'h32;
   localparam logic [7:0] CMD_LEGACY    = 8'h02;
   localparam logic [7:0] SUB_CTRL_A    = 8'h11;
   localparam logic [7:0] SUB_CTRL_B    = 8'h13;
   localparam logic [7:0] SUB_CTRL_C    = 8'h14;
   localparam logic [7:0] SUB_CTRL_D    = 8'h90;
   localparam logic [7:0] SUB_CTRL_E    = 8'h91;
   localparam logic [7:0] SUB_SERIAL    = 8'h24;
   localparam logic [7:0] SUB_LEGACY    = 8'h46;
   localparam logic [7:0] ACK_LEN_BYTE  = 8'h02;
   localparam logic [7:0] SER_LEN_BYTE  = 8'h08;

   // Frame overhead beyond the payload: marker, two length bytes, checksum, trailer
   localparam logic [16:0] FRAME_OVERHEAD = 17'd5;

   // Response lengths in bytes
   localparam int RSP_POS_W = 5;
   localparam logic [RSP_POS_W-1:0] ACK_FRAME_LEN    = 5'd7;
   localparam logic [RSP_POS_W-1:0] SERIAL_FRAME_LEN = 5'd13;

   // Job queue between parser and responder
   localparam int JOB_DEPTH = 4;
   localparam int JOB_PTR_W = 2;
   localparam int JOB_CNT_W = 3;

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_START_MARKER = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_MARKER   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CARD_SERIAL  = 2'd2;
   localparam int CSR_DATA_W = 48;

   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_LEN_HI  = 3'd1,
      PH_LEN_LO  = 3'd2,
      PH_PAYLOAD = 3'd3,
      PH_CHECK   = 3'd4,
      PH_TRAIL   = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_ACK    = 2'd1,
      KIND_SERIAL = 2'd2
   } kind_type;

   typedef struct packed {
      logic     nak;
      kind_type kind;
   } job_type;

endpackage

`default_nettype wire

// ===== hw/rtl/cfpr_parser.sv =====
// Front end: frame parser that walks received bytes and classifies finished frames.
// Depends on cfpr_pkg; pushes one job per frame that needs a response.
`default_nettype none

module cfpr_parser #(
   parameter int MAX_FRAME = 1024
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           rx_fire,
   input  wire logic [7:0]     rx_byte,
   input  wire logic [7:0]     start_marker,
   input  wire logic           queue_full,
   output logic                rx_ready,
   output logic                job_push,
   output cfpr_pkg::job_type   job
);

   localparam logic [16:0] MaxFrame = 17'(MAX_FRAME);

   cfpr_pkg::phase_type phase_ff, phase_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] seen_ff, seen_in;
   logic [7:0]  xor_ff, xor_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [7:0]  sub_ff, sub_in;
   logic        bad_ff, bad_in;
   logic [15:0] len_full;
   logic [16:0] seen_next;
   logic        ctrl_sub;
   cfpr_pkg::kind_type kind;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= cfpr_pkg::PH_HUNT;
         len_ff   <= '0;
         seen_ff  <= '0;
         xor_ff   <= '0;
         cmd_ff   <= '0;
         sub_ff   <= '0;
         bad_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         len_ff   <= len_in;
         seen_ff  <= seen_in;
         xor_ff   <= xor_in;
         cmd_ff   <= cmd_in;
         sub_ff   <= sub_in;
         bad_ff   <= bad_in;
      end
   end

   // Classify the frame from the command and sub-command bytes
   always_comb begin
      ctrl_sub = (sub_ff == cfpr_pkg::SUB_CTRL_A) || (sub_ff == cfpr_pkg::SUB_CTRL_B) ||
                 (sub_ff == cfpr_pkg::SUB_CTRL_C) || (sub_ff == cfpr_pkg::SUB_CTRL_D) ||
                 (sub_ff == cfpr_pkg::SUB_CTRL_E);
      kind = cfpr_pkg::KIND_NONE;
      if (len_ff >= 16'd2) begin
         priority if (cmd_ff == cfpr_pkg::CMD_CONTROL && ctrl_sub) begin
            kind = cfpr_pkg::KIND_ACK;
         end else if (cmd_ff == cfpr_pkg::CMD_LEGACY && sub_ff == cfpr_pkg::SUB_LEGACY) begin
            kind = cfpr_pkg::KIND_ACK;
         end else if (cmd_ff == cfpr_pkg::CMD_QUERY && sub_ff == cfpr_pkg::SUB_SERIAL) begin
            kind = cfpr_pkg::KIND_SERIAL;
         end else begin
            kind = cfpr_pkg::KIND_NONE;
         end
      end
   end

   assign job.nak  = bad_ff;
   assign job.kind = kind;

   // Hold the trailer byte while the queue has no room
   assign rx_ready = !(phase_ff == cfpr_pkg::PH_TRAIL && queue_full);

   assign len_full  = {len_ff[15:8], rx_byte};
   assign seen_next = {1'b0, seen_ff} + 17'd1;

   always_comb begin
      phase_in = phase_ff;
      len_in   = len_ff;
      seen_in  = seen_ff;
      xor_in   = xor_ff;
      cmd_in   = cmd_ff;
      sub_in   = sub_ff;
      bad_in   = bad_ff;
      job_push = 1'b0;
      if (rx_fire) begin
         unique case (phase_ff)
            cfpr_pkg::PH_HUNT: begin
               if (rx_byte == start_marker) begin
                  phase_in = cfpr_pkg::PH_LEN_HI;
                  len_in   = '0;
                  seen_in  = '0;
                  xor_in   = '0;
                  cmd_in   = '0;
                  sub_in   = '0;
                  bad_in   = 1'b0;
               end
            end
            cfpr_pkg::PH_LEN_HI: begin
               len_in   = {rx_byte, 8'h00};
               phase_in = cfpr_pkg::PH_LEN_LO;
            end
            cfpr_pkg::PH_LEN_LO: begin
               len_in = len_full;
               priority if ({1'b0, len_full} + cfpr_pkg::FRAME_OVERHEAD > MaxFrame) begin
                  phase_in = cfpr_pkg::PH_HUNT;
               end else if (len_full == 16'd0) begin
                  phase_in = cfpr_pkg::PH_CHECK;
               end else begin
                  phase_in = cfpr_pkg::PH_PAYLOAD;
               end
            end
            cfpr_pkg::PH_PAYLOAD: begin
               if (seen_ff == 16'd0) begin
                  cmd_in = rx_byte;
               end else if (seen_ff == 16'd1) begin
                  sub_in = rx_byte;
               end
               xor_in  = xor_ff ^ rx_byte;
               seen_in = seen_next[15:0];
               if (seen_next >= {1'b0, len_ff}) begin
                  phase_in = cfpr_pkg::PH_CHECK;
               end
            end
            cfpr_pkg::PH_CHECK: begin
               bad_in   = (rx_byte != xor_ff);
               phase_in = cfpr_pkg::PH_TRAIL;
            end
            cfpr_pkg::PH_TRAIL: begin
               job_push = bad_ff || (kind != cfpr_pkg::KIND_NONE);
               phase_in = cfpr_pkg::PH_HUNT;
            end
            default: begin
               phase_in = cfpr_pkg::PH_HUNT;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/cfpr_job_queue.sv =====
// Short job queue between the parser and the responder.
// Depends on cfpr_pkg for the job type and depth.
`default_nettype none

module cfpr_job_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire cfpr_pkg::job_type push_job,
   input  wire logic              pop,
   output cfpr_pkg::job_type      head_job,
   output logic                   empty,
   output logic                   full
);

   cfpr_pkg::job_type slot_ff [cfpr_pkg::JOB_DEPTH];
   logic [cfpr_pkg::JOB_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [cfpr_pkg::JOB_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [cfpr_pkg::JOB_CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == cfpr_pkg::JOB_CNT_W'(cfpr_pkg::JOB_DEPTH));
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/cfpr_responder.sv =====
// Back end: sequences the response bytes of one job at a time into an output register.
// Depends on cfpr_pkg; takes jobs from cfpr_job_queue.
`default_nettype none

module cfpr_responder (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              job_valid,
   input  wire cfpr_pkg::job_type job,
   output logic                   job_pop,
   input  wire logic [7:0]        start_marker,
   input  wire logic [7:0]        end_marker,
   input  wire logic [47:0]       card_serial,
   output logic                   tx_valid,
   input  wire logic              tx_ready,
   output logic [7:0]             tx_byte,
   output logic                   tx_last
);

   localparam int PW = cfpr_pkg::RSP_POS_W;

   logic              active_ff, active_in;
   cfpr_pkg::job_type job_ff, job_in;
   logic [PW-1:0]     pos_ff, pos_in;
   logic              out_valid_ff, out_valid_in;
   logic [7:0]        out_byte_ff, out_byte_in;
   logic              out_last_ff, out_last_in;
   logic              can_load;
   logic [PW-1:0]     frame_len, total_len, frame_pos;
   logic              at_last;
   logic [7:0]        frame_byte, cur_byte, serial_xor;

   assign serial_xor = card_serial[47:40] ^ card_serial[39:32] ^ card_serial[31:24] ^
                       card_serial[23:16] ^ card_serial[15:8]  ^ card_serial[7:0];

   always_comb begin
      unique case (job_ff.kind)
         cfpr_pkg::KIND_ACK:    frame_len = cfpr_pkg::ACK_FRAME_LEN;
         cfpr_pkg::KIND_SERIAL: frame_len = cfpr_pkg::SERIAL_FRAME_LEN;
         default:               frame_len = '0;
      endcase
   end

   assign total_len = frame_len + PW'(job_ff.nak);
   assign at_last   = (pos_ff == total_len - 1'b1);
   assign frame_pos = pos_ff - PW'(job_ff.nak);

   // Byte of the response frame at its position
   always_comb begin
      unique case (frame_pos)
         5'd0:    frame_byte = start_marker;
         5'd2:    frame_byte = (job_ff.kind == cfpr_pkg::KIND_SERIAL) ?
                               cfpr_pkg::SER_LEN_BYTE : cfpr_pkg::ACK_LEN_BYTE;
         5'd5:    frame_byte = (job_ff.kind == cfpr_pkg::KIND_SERIAL) ?
                               card_serial[47:40] : 8'h00;
         5'd6:    frame_byte = (job_ff.kind == cfpr_pkg::KIND_SERIAL) ?
                               card_serial[39:32] : end_marker;
         5'd7:    frame_byte = card_serial[31:24];
         5'd8:    frame_byte = card_serial[23:16];
         5'd9:    frame_byte = card_serial[15:8];
         5'd10:   frame_byte = card_serial[7:0];
         5'd11:   frame_byte = serial_xor;
         5'd12:   frame_byte = end_marker;
         default: frame_byte = 8'h00;
      endcase
   end

   assign cur_byte = (job_ff.nak && pos_ff == '0) ? cfpr_pkg::NAK_BYTE : frame_byte;
   assign can_load = !out_valid_ff || tx_ready;

   always_comb begin
      active_in    = active_ff;
      job_in       = job_ff;
      pos_in       = pos_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (can_load) begin
         out_valid_in = active_ff;
         out_byte_in  = cur_byte;
         out_last_in  = at_last;
         if (active_ff) begin
            pos_in = pos_ff + 1'b1;
            if (at_last) begin
               active_in = 1'b0;
            end
         end
      end
      // Take the next job as the current one finishes
      job_pop = job_valid && (!active_ff || (can_load && at_last));
      if (job_pop) begin
         active_in = 1'b1;
         job_in    = job;
         pos_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      pos_ff      <= pos_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign tx_valid = out_valid_ff;
   assign tx_byte  = out_byte_ff;
   assign tx_last  = out_last_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/card_frame_parser_responder_core.sv =====
// Top level of the card frame parser and responder: config registers, parser, queue, responder.
// Depends on cfpr_pkg, cfpr_parser, cfpr_job_queue and cfpr_responder.
// Throughput: one received byte per cycle; the parser stalls only on a trailer byte
//   while the four-entry job queue is full. Responses drain at one byte per cycle while rsp_tready is high.
// Response path: when the back end is idle, a job written to the queue at the edge that
//   accepts the trailer byte passes through the responder job register, then the first
//   response byte is loaded into the output register.
// Reset: synchronous, active high; parser hunts, queue and output empty, registers at defaults.
`default_nettype none

module card_frame_parser_responder_core #(
   parameter int MAX_FRAME = 1024
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Received byte stream
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [7:0]                        req_tdata,   // [7:0] rx_byte
   // Response byte stream
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [7:0]                             rsp_tdata,   // [7:0] tx_byte
   output logic                                   rsp_tlast,   // last_of_response
   // Configuration writes
   input  wire logic                              csr_we,
   input  wire logic [cfpr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [cfpr_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic [7:0]  start_marker_ff;
   logic [7:0]  end_marker_ff;
   logic [47:0] card_serial_ff;

   logic              rx_fire;
   logic              job_push, job_pop, queue_empty, queue_full;
   cfpr_pkg::job_type push_job, head_job;

   // Configuration registers; writes to an unused index are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= 8'h02;
         end_marker_ff   <= 8'h03;
         card_serial_ff  <= 48'd28606513737142;
      end else if (csr_we) begin
         unique case (csr_index)
            cfpr_pkg::CSR_START_MARKER: start_marker_ff <= csr_wdata[7:0];
            cfpr_pkg::CSR_END_MARKER:   end_marker_ff   <= csr_wdata[7:0];
            cfpr_pkg::CSR_CARD_SERIAL:  card_serial_ff  <= csr_wdata[47:0];
            default: begin
            end
         endcase
      end
   end

   assign rx_fire = req_tvalid && req_tready;

   // Front end: parse and classify each frame
   cfpr_parser #(
      .MAX_FRAME(MAX_FRAME)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .rx_fire      (rx_fire),
      .rx_byte      (req_tdata),
      .start_marker (start_marker_ff),
      .queue_full   (queue_full),
      .rx_ready     (req_tready),
      .job_push     (job_push),
      .job          (push_job)
   );

   // Decouple parser from responder
   cfpr_job_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .pop      (job_pop),
      .head_job (head_job),
      .empty    (queue_empty),
      .full     (queue_full)
   );

   // Back end: emit NAK and response frame bytes
   cfpr_responder u_responder (
      .clock        (clock),
      .reset        (reset),
      .job_valid    (!queue_empty),
      .job          (head_job),
      .job_pop      (job_pop),
      .start_marker (start_marker_ff),
      .end_marker   (end_marker_ff),
      .card_serial  (card_serial_ff),
      .tx_valid     (rsp_tvalid),
      .tx_ready     (rsp_tready),
      .tx_byte      (rsp_tdata),
      .tx_last      (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/cfpr_checker.sv =====
// Port-level checks for card_frame_parser_responder_core, bound to the top level.
// Depends on cfpr_pkg for the NAK byte and register indexes.
`default_nettype none

module cfpr_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [7:0]                      rsp_tdata,
   input wire logic                            rsp_tlast,
   input wire logic                            csr_we,
   input wire logic [cfpr_pkg::CSR_IDX_W-1:0]  csr_index,
   input wire logic [cfpr_pkg::CSR_DATA_W-1:0] csr_wdata
);

   logic [7:0] end_marker_ff;

   // Shadow the end marker to check response frame endings
   always_ff @(posedge clock) begin
      if (reset) begin
         end_marker_ff <= 8'h03;
      end else if (csr_we && csr_index == cfpr_pkg::CSR_END_MARKER) begin
         end_marker_ff <= csr_wdata[7:0];
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("response item changed while stalled");

   a_rsp_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_req_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("input not ready right after reset");

   a_last_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |->
         rsp_tdata == cfpr_pkg::NAK_BYTE || rsp_tdata == end_marker_ff)
      else $error("last response byte is neither NAK nor end marker");

endmodule

bind card_frame_parser_responder_core cfpr_checker u_cfpr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .csr_we     (csr_we),
   .csr_index  (csr_index),
   .csr_wdata  (csr_wdata)
);

`default_nettype wire

// ===== dv/cfpr_response_checker.sv =====
// Watches the byte and response streams of card_frame_parser_responder_core, predicts
// the response bytes of every received byte and compares them. Depends on cfpr_pkg.
`default_nettype none

module cfpr_response_checker #(
   parameter int MAX_FRAME = 1024
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   input  wire logic                              req_tready,
   input  wire logic [7:0]                        req_tdata,   // [7:0] rx_byte
   input  wire logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic [7:0]                        rsp_tdata,   // [7:0] tx_byte
   input  wire logic                              rsp_tlast,   // last_of_response
   input  wire logic                              csr_we,
   input  wire logic [cfpr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [cfpr_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int                                     mismatch_count,
   output int                                     pending_count
);

   import cfpr_pkg::*;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last_of_response;
   } tx_beat_t;

   tx_beat_t    expected_tx [$];

   // Register mirror
   logic [7:0]  marker_open;
   logic [7:0]  marker_close;
   logic [47:0] serial_id;

   // Parser mirror
   phase_type   phase;
   logic [15:0] frame_len;
   logic [15:0] payload_count;
   logic [7:0]  payload_xor;
   logic [7:0]  cmd_code;
   logic [7:0]  sub_code;
   logic        sum_error;

   // Advance the parser by one received byte; queue the bytes it answers with.
   task automatic absorb_rx_byte(input logic [7:0] rx);
      logic [7:0]  reply [$];
      logic [7:0]  fold;
      logic [7:0]  part;
      logic [16:0] total;
      logic        ack_hit;
      logic        serial_hit;
      reply = {};
      case (phase)
         PH_HUNT: begin
            if (rx == marker_open) begin
               phase         = PH_LEN_HI;
               frame_len     = '0;
               payload_count = '0;
               payload_xor   = '0;
               cmd_code      = '0;
               sub_code      = '0;
               sum_error     = 1'b0;
            end
         end
         PH_LEN_HI: begin
            frame_len = {rx, 8'h00};
            phase     = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            frame_len = frame_len | {8'h00, rx};
            total     = {1'b0, frame_len} + FRAME_OVERHEAD;
            if (int'(total) > MAX_FRAME)
               phase = PH_HUNT;
            else if (frame_len == 16'd0)
               phase = PH_CHECK;
            else
               phase = PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            if (payload_count == 16'd0)
               cmd_code = rx;
            else if (payload_count == 16'd1)
               sub_code = rx;
            payload_xor   = payload_xor ^ rx;
            payload_count = payload_count + 16'd1;
            if (payload_count >= frame_len)
               phase = PH_CHECK;
         end
         PH_CHECK: begin
            sum_error = (rx != payload_xor);
            phase     = PH_TRAIL;
         end
         PH_TRAIL: begin
            ack_hit    = 1'b0;
            serial_hit = 1'b0;
            if (sum_error)
               reply.push_back(NAK_BYTE);
            if (frame_len >= 16'd2) begin
               if (cmd_code == CMD_CONTROL && (sub_code == SUB_CTRL_A ||
                   sub_code == SUB_CTRL_B || sub_code == SUB_CTRL_C ||
                   sub_code == SUB_CTRL_D || sub_code == SUB_CTRL_E))
                  ack_hit = 1'b1;
               else if (cmd_code == CMD_LEGACY && sub_code == SUB_LEGACY)
                  ack_hit = 1'b1;
               else if (cmd_code == CMD_QUERY && sub_code == SUB_SERIAL)
                  serial_hit = 1'b1;
            end
            if (ack_hit) begin
               reply.push_back(marker_open);
               reply.push_back(8'h00);
               reply.push_back(ACK_LEN_BYTE);
               reply.push_back(8'h00);
               reply.push_back(8'h00);
               reply.push_back(8'h00);
               reply.push_back(marker_close);
            end else if (serial_hit) begin
               reply.push_back(marker_open);
               reply.push_back(8'h00);
               reply.push_back(SER_LEN_BYTE);
               reply.push_back(8'h00);
               reply.push_back(8'h00);
               fold = '0;
               for (int k = 5; k >= 0; k--) begin
                  part = serial_id[k*8 +: 8];
                  fold = fold ^ part;
                  reply.push_back(part);
               end
               reply.push_back(fold);
               reply.push_back(marker_close);
            end
            phase = PH_HUNT;
         end
         default: phase = PH_HUNT;
      endcase
      foreach (reply[k])
         expected_tx.push_back(tx_beat_t'{reply[k], (k == reply.size() - 1)});
   endtask

   always @(posedge clock) begin
      tx_beat_t want;
      if (reset) begin
         expected_tx.delete();
         marker_open    = 8'h02;
         marker_close   = 8'h03;
         serial_id      = 48'd28606513737142;
         phase          = PH_HUNT;
         frame_len      = '0;
         payload_count  = '0;
         payload_xor    = '0;
         cmd_code       = '0;
         sub_code       = '0;
         sum_error      = 1'b0;
         mismatch_count = 0;
         pending_count  = 0;
      end else begin
         // Check the response side first: an item leaving now belongs to older frames.
         if (rsp_tvalid && rsp_tready) begin
            if (expected_tx.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected response item: expected none, got tx_byte %02h last %0b",
                        $time, rsp_tdata, rsp_tlast);
            end else begin
               want = expected_tx.pop_front();
               if (want.tx_byte !== rsp_tdata) begin
                  mismatch_count++;
                  $display("%0t: tx_byte mismatch: expected %02h, got %02h",
                           $time, want.tx_byte, rsp_tdata);
               end
               if (want.last_of_response !== rsp_tlast) begin
                  mismatch_count++;
                  $display("%0t: last_of_response mismatch: expected %0b, got %0b",
                           $time, want.last_of_response, rsp_tlast);
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_START_MARKER: marker_open  = csr_wdata[7:0];
               CSR_END_MARKER:   marker_close = csr_wdata[7:0];
               CSR_CARD_SERIAL:  serial_id    = csr_wdata[47:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            absorb_rx_byte(req_tdata);
         pending_count = expected_tx.size();
      end
   end

endmodule

`default_nettype wire

// ===== dv/card_frame_parser_responder_core_tb.sv =====
// Top of the frame parser testbench: clock, reset, byte stimulus, response backpressure,
// register writes and the verdict. Depends on cfpr_pkg, the core and cfpr_response_checker.
`default_nettype none

module card_frame_parser_responder_core_tb;

   import cfpr_pkg::*;

   // Cycles without any accepted item before the run is declared hung
   localparam int STUCK_LIMIT = 3000;
   // Index past the register list; the block must ignore writes to it
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;    // [7:0] rx_byte
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [7:0]            rsp_tdata;    // [7:0] tx_byte
   logic                  rsp_tlast;    // last_of_response
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int                    mismatch_count;
   int                    pending_count;

   // Stimulus controls shared by the sender and receiver processes
   bit                    pace_on;
   int                    hold_off_cycles;
   int                    sent_count;
   int                    stuck_cycles;
   logic [7:0]            marker;
   logic [7:0]            frame_body [$];
   logic [7:0]            ctrl_subs [5];

   card_frame_parser_responder_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   cfpr_response_checker u_response_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hang detector: count cycles in which neither channel moves an item.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   // Offer one received byte; return at the edge that accepts it.
   // Drive at the falling edge, so valid is never lowered and raised in one step.
   task automatic send_byte(input logic [7:0] value);
      int gap;
      gap = pace_on ? $urandom_range(0, 12) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      sent_count++;
   endtask

   // Frame the bytes in frame_body: marker, big-endian length, payload, checksum, trailer.
   task automatic send_frame(input bit corrupt);
      logic [7:0]  fold;
      logic [15:0] len;
      fold = '0;
      foreach (frame_body[k])
         fold = fold ^ frame_body[k];
      len = 16'(frame_body.size());
      send_byte(marker);
      send_byte(len[15:8]);
      send_byte(len[7:0]);
      foreach (frame_body[k])
         send_byte(frame_body[k]);
      // A corrupted checksum always differs from the payload XOR.
      send_byte(corrupt ? fold ^ 8'($urandom_range(1, 255)) : fold);
      send_byte(8'($urandom));
   endtask

   // Mostly well-formed frames with random content; the rest is noise and broken frames.
   task automatic send_random_frame();
      int          pick;
      int          sel;
      logic [7:0]  stray;
      logic [15:0] len;
      pick = $urandom_range(0, 99);
      frame_body = {};
      if (pick < 10) begin
         // Line noise while hunting; keep it off the marker so framing stays aligned.
         repeat ($urandom_range(1, 3)) begin
            stray = 8'($urandom);
            if (stray == marker)
               stray = ~stray;
            send_byte(stray);
         end
      end else if (pick < 18) begin
         // Over-long length: the parser drops back to hunting after the length bytes.
         len = 16'($urandom_range(1020, 65535));
         send_byte(marker);
         send_byte(len[15:8]);
         send_byte(len[7:0]);
      end else if (pick < 78) begin
         sel = $urandom_range(0, 6);
         if (sel < 5) begin
            frame_body.push_back(CMD_CONTROL);
            frame_body.push_back(ctrl_subs[sel]);
         end else if (sel == 5) begin
            frame_body.push_back(CMD_LEGACY);
            frame_body.push_back(SUB_LEGACY);
         end else begin
            frame_body.push_back(CMD_QUERY);
            frame_body.push_back(SUB_SERIAL);
         end
         repeat ($urandom_range(0, 4))
            frame_body.push_back(8'($urandom));
         send_frame($urandom_range(0, 7) == 0);
      end else begin
         // Unknown commands and short or empty payloads
         repeat ($urandom_range(0, 6))
            frame_body.push_back(8'($urandom));
         send_frame($urandom_range(0, 3) == 0);
      end
   endtask

   task automatic send_random_run(input int count);
      int stop_at;
      stop_at = sent_count + count;
      while (sent_count < stop_at)
         send_random_frame();
   endtask

   // Release the input and wait out every expected response plus the pipeline tail.
   task automatic drain_responses();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_count != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      if (index == CSR_START_MARKER)
         marker = data[7:0];
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic logic [CSR_DATA_W-1:0] random_word();
      return CSR_DATA_W'({$urandom, $urandom});
   endfunction

   // Response side: stall a random number of cycles per item, or one long hold-off.
   initial begin
      int gap;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_off_cycles) @(negedge clock);
            hold_off_cycles = 0;
         end else begin
            gap = pace_on ? $urandom_range(0, 12) : 0;
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      csr_we          = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      pace_on         = 1'b1;
      hold_off_cycles = 0;
      sent_count      = 0;
      stuck_cycles    = 0;
      marker          = 8'h02;
      ctrl_subs       = '{SUB_CTRL_A, SUB_CTRL_B, SUB_CTRL_C, SUB_CTRL_D, SUB_CTRL_E};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed frames under the reset register values
      send_byte(8'h55);                       // noise while hunting
      frame_body = {CMD_CONTROL, SUB_CTRL_A};
      send_frame(1'b0);                       // plain ack
      frame_body = {CMD_QUERY, SUB_SERIAL};
      send_frame(1'b1);                       // checksum mismatch: NAK, then serial frame
      frame_body = {CMD_CONTROL};
      send_frame(1'b1);                       // short payload: NAK only, no dispatch
      send_byte(marker);                      // smallest over-long length, 1020
      send_byte(8'h03);
      send_byte(8'hFC);
      drain_responses();

      // Zero start marker, all-ones end marker and serial; junk to the unused index
      write_csr(CSR_START_MARKER, 48'h0);
      write_csr(CSR_END_MARKER, 48'hFF);
      write_csr(CSR_CARD_SERIAL, 48'hFFFF_FFFF_FFFF);
      write_csr(CSR_UNUSED, random_word());
      send_random_run(20);
      drain_responses();

      // All-ones start marker, zero end marker and serial; run without idling
      write_csr(CSR_START_MARKER, 48'hFF);
      write_csr(CSR_END_MARKER, 48'h0);
      write_csr(CSR_CARD_SERIAL, 48'h0);
      pace_on = 1'b0;
      send_random_run(20);
      drain_responses();

      // Random registers with upper data bits set; hold the response side off
      // while acks pile up, so the job queue fills and the input stalls
      write_csr(CSR_START_MARKER, random_word());
      write_csr(CSR_END_MARKER, random_word());
      write_csr(CSR_CARD_SERIAL, random_word());
      hold_off_cycles = 400;
      repeat (8) begin
         frame_body = {CMD_LEGACY, SUB_LEGACY};
         send_frame(1'b0);
      end
      drain_responses();
      pace_on = 1'b1;
      send_random_run(20);
      drain_responses();

      write_csr(CSR_START_MARKER, random_word());
      write_csr(CSR_END_MARKER, random_word());
      write_csr(CSR_CARD_SERIAL, random_word());
      send_random_run(20);
      drain_responses();

      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire

// ===== card_frame_parser_responder_core.f =====
hw/rtl/cfpr_pkg.sv
hw/rtl/cfpr_parser.sv
hw/rtl/cfpr_job_queue.sv
hw/rtl/cfpr_responder.sv
hw/rtl/card_frame_parser_responder_core.sv
hw/rtl/cfpr_checker.sv
dv/cfpr_response_checker.sv
dv/card_frame_parser_responder_core_tb.sv
